>>> sv/softmax_top_k_select_top_macros.svh
// Assertion macros for the top-k softmax block.
// Used by softmax_top_k_select_top; no other dependencies.
`ifndef SOFTMAX_TOP_K_SELECT_TOP_MACROS_SVH
`define SOFTMAX_TOP_K_SELECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMPL(label, clk, rst, antecedent, consequent, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (antecedent) |-> (consequent)) \
      else $error(msg);
`define SMX_ASSERT_NEXT(label, clk, rst, antecedent, consequent, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (antecedent) |=> (consequent)) \
      else $error(msg);
`else
`define SMX_ASSERT_IMPL(label, clk, rst, antecedent, consequent, msg)
`define SMX_ASSERT_NEXT(label, clk, rst, antecedent, consequent, msg)
`endif
`endif

>>> sv/smx_topk_pkg.sv
// Package for the top-k softmax block: widths, exp tables and shared types.
// Used by every module of the block but smx_topk_ram; depends on nothing.
package smx_topk_pkg;
   localparam int MaxClassesDefault = 1024;
   localparam int MaxTopDefault     = 8;
   localparam int TopCountReset     = 5;
   localparam int ScoreWidth        = 16;
   localparam int IndexWidth        = 10;
   localparam int ProbWidth         = 16;
   localparam int TopWidth          = 4;
   localparam int ExpWidth          = 17;

   // Request handed from the front part to the back part.
   typedef struct packed {
      logic                         store;  // score is within capacity
      logic                         last;
      logic signed [ScoreWidth-1:0] score;
   } smx_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_DIV_SETUP,
      ST_DIV_RUN,
      ST_EMIT
   } smx_state_type;

   function automatic logic [16:0] exp_int(input logic [3:0] i);
      logic [16:0] v;
      begin
         case (i)
            4'd0: v = 17'd65536;  4'd1: v = 17'd24109;  4'd2: v = 17'd8869;
            4'd3: v = 17'd3263;   4'd4: v = 17'd1200;   4'd5: v = 17'd442;
            4'd6: v = 17'd162;    4'd7: v = 17'd60;     4'd8: v = 17'd22;
            4'd9: v = 17'd8;      4'd10: v = 17'd3;     4'd11: v = 17'd1;
            default: v = 17'd0;
         endcase
         return v;
      end
   endfunction

   function automatic logic [16:0] exp_hi(input logic [3:0] h);
      logic [16:0] v;
      begin
         case (h)
            4'd0: v = 17'd65536;  4'd1: v = 17'd61565;  4'd2: v = 17'd57835;
            4'd3: v = 17'd54331;  4'd4: v = 17'd51039;  4'd5: v = 17'd47947;
            4'd6: v = 17'd45042;  4'd7: v = 17'd42313;  4'd8: v = 17'd39750;
            4'd9: v = 17'd37341;  4'd10: v = 17'd35079; 4'd11: v = 17'd32954;
            4'd12: v = 17'd30957; 4'd13: v = 17'd29081; 4'd14: v = 17'd27319;
            default: v = 17'd25664;
         endcase
         return v;
      end
   endfunction

   function automatic logic [16:0] exp_lo(input logic [3:0] l);
      logic [16:0] v;
      begin
         case (l)
            4'd0: v = 17'd65536;  4'd1: v = 17'd65280;  4'd2: v = 17'd65026;
            4'd3: v = 17'd64772;  4'd4: v = 17'd64520;  4'd5: v = 17'd64268;
            4'd6: v = 17'd64018;  4'd7: v = 17'd63768;  4'd8: v = 17'd63520;
            4'd9: v = 17'd63272;  4'd10: v = 17'd63025; 4'd11: v = 17'd62780;
            4'd12: v = 17'd62535; 4'd13: v = 17'd62291; 4'd14: v = 17'd62048;
            default: v = 17'd61806;
         endcase
         return v;
      end
   endfunction
endpackage

>>> sv/smx_topk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module smx_topk_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> sv/smx_topk_front.sv
// Front part: accepts score requests, tracks capacity, pushes them into a queue.
// Depends on smx_topk_pkg.
module smx_topk_front
   import smx_topk_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault,
   parameter int QDepth     = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [ScoreWidth-1:0] logit,
   input  logic                         last,
   output logic                         full,
   input  logic                         pop,
   output logic                         q_valid,
   output smx_req_type                  q_head
);
   localparam int CntW = $clog2(MaxClasses + 1);
   localparam int QaW  = $clog2(QDepth);

   smx_req_type      q_ff [QDepth];
   logic [QaW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QaW:0]     cnt_ff, cnt_in;
   logic [CntW-1:0]  seen_ff, seen_in;
   logic             push;

   assign full    = (cnt_ff == (QaW+1)'(QDepth));
   assign push    = start && !full;
   assign q_valid = (cnt_ff != '0);
   assign q_head  = q_ff[rp_ff];

   always_comb begin
      wp_in   = push ? wp_ff + 1'b1 : wp_ff;
      rp_in   = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in  = cnt_ff + (QaW+1)'(push) - (QaW+1)'(pop);
      seen_in = seen_ff;
      if (push) begin
         if (last) begin
            seen_in = '0;
         end else if (seen_ff != CntW'(MaxClasses)) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         seen_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
         seen_ff <= seen_in;
      end
      if (push) begin
         q_ff[wp_ff].store <= (seen_ff != CntW'(MaxClasses));
         q_ff[wp_ff].last  <= last;
         q_ff[wp_ff].score <= logit;
      end
   end
endmodule

>>> sv/smx_topk_rank.sv
// Sorted list of the best scores, one insertion per cycle, as a row of cells.
// Depends on smx_topk_pkg.
module smx_topk_rank
   import smx_topk_pkg::*;
#(
   parameter int MaxTop = MaxTopDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         ins,
   input  logic [IndexWidth-1:0]        ins_index,
   input  logic signed [ScoreWidth-1:0] ins_score,
   input  logic [$clog2(MaxTop)-1:0]    rd_sel,
   output logic [IndexWidth-1:0]        rd_index,
   output logic signed [ScoreWidth-1:0] rd_score,
   output logic signed [ScoreWidth-1:0] top_score,
   output logic [$clog2(MaxTop+1)-1:0]  filled
);
   localparam int FW = $clog2(MaxTop + 1);

   logic [IndexWidth-1:0]        idx_ff [MaxTop];
   logic signed [ScoreWidth-1:0] sc_ff  [MaxTop];
   logic [MaxTop-1:0]            val_ff, val_in, beat;
   logic [FW-1:0]                filled_ff;

   // A cell is beaten when it is empty or holds a strictly lower score.
   always_comb begin
      for (int j = 0; j < MaxTop; j++) begin
         beat[j] = !val_ff[j] || (sc_ff[j] < ins_score);
      end
      val_in = {val_ff[MaxTop-2:0], 1'b1} | val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         val_ff    <= '0;
         filled_ff <= '0;
      end else if (ins) begin
         val_ff <= val_in;
         if (filled_ff != FW'(MaxTop)) filled_ff <= filled_ff + 1'b1;
      end
      if (ins) begin
         for (int j = 0; j < MaxTop; j++) begin
            if (beat[j]) begin
               if (j == 0 || !beat[(j == 0) ? 0 : j-1]) begin
                  idx_ff[j] <= ins_index;
                  sc_ff[j]  <= ins_score;
               end else begin
                  idx_ff[j] <= idx_ff[(j == 0) ? 0 : j-1];
                  sc_ff[j]  <= sc_ff[(j == 0) ? 0 : j-1];
               end
            end
         end
      end
   end

   assign rd_index  = idx_ff[rd_sel];
   assign rd_score  = sc_ff[rd_sel];
   assign top_score = sc_ff[0];
   assign filled    = filled_ff;
endmodule

>>> sv/smx_topk_back.sv
// Back part: stores and ranks scores, sums the exp values, divides and emits.
// Depends on smx_topk_pkg, smx_topk_ram and smx_topk_rank.
module smx_topk_back
   import smx_topk_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault,
   parameter int MaxTop     = MaxTopDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  smx_req_type           q_head,
   output logic                  pop,
   input  logic [TopWidth-1:0]   top_count,
   output logic                  out_valid,
   output logic [IndexWidth-1:0] out_index,
   output logic [ProbWidth-1:0]  out_prob,
   output logic                  out_final,
   output logic                  working
);
   localparam int AW   = $clog2(MaxClasses);
   localparam int CW   = $clog2(MaxClasses + 1);
   localparam int TW   = $clog2(MaxTop);
   localparam int FW   = $clog2(MaxTop + 1);
   localparam int SumW = ExpWidth + CW;
   localparam int QW   = 17;

   smx_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, rd_ff;
   logic [SumW-1:0] sum_ff;
   logic [TW-1:0]   r_ff;
   logic [FW-1:0]   n_ff;
   logic [4:0]      bit_ff;
   logic [SumW:0]   rem_ff, rem_sh, trial;
   logic [32:0]     num_ff, num_load;
   logic [QW-1:0]   quo_ff;
   logic signed [ScoreWidth-1:0] rd_data, mx, best_sc, exp_arg;
   logic [IndexWidth-1:0] best_ix;
   logic [FW-1:0]   filled;
   logic            ins, do_store;
   logic [16:0]     d, e_val, te_val, t_ff;
   logic [33:0]     t_prod, e_prod;
   logic [5:0]      lo_ff;
   logic [16:0]     cnt_sat;
   logic [FW-1:0]   k_eff;
   logic [AW-1:0]   wr_addr;
   logic [1:0]      pv_ff;

   assign do_store = q_head.store;
   assign pop      = q_valid && (state_ff == ST_IDLE);
   assign ins      = pop && do_store;
   assign wr_addr  = cnt_ff[AW-1:0];

   smx_topk_ram #(.Width(ScoreWidth), .Depth(MaxClasses)) u_ram (
      .clock   (clock),
      .wr_en   (ins),
      .wr_addr (wr_addr),
      .wr_data (q_head.score),
      .rd_addr (rd_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   smx_topk_rank #(.MaxTop(MaxTop)) u_rank (
      .clock     (clock),
      .reset     (reset),
      .clear     (state_ff == ST_EMIT && (FW'(r_ff) + 1'b1 == n_ff)),
      .ins       (ins),
      .ins_index (IndexWidth'(cnt_ff)),
      .ins_score (q_head.score),
      .rd_sel    (r_ff),
      .rd_index  (best_ix),
      .rd_score  (best_sc),
      .top_score (mx),
      .filled    (filled)
   );

   // Exp of the difference in two steps: registered table product, then low term.
   assign exp_arg = (state_ff == ST_SUM_RD) ? rd_data : best_sc;
   assign d       = 17'(mx) - 17'(exp_arg);
   assign t_prod  = exp_int(d[11:8]) * exp_hi(d[7:4]) + 34'd32768;
   assign e_prod  = t_ff * exp_lo(lo_ff[3:0]) + 34'd32768;
   assign e_val   = lo_ff[5] ? 17'd0 : e_prod[32:16];
   assign te_val  = e_val;

   always_comb begin
      if (top_count == '0)                    k_eff = FW'(1);
      else if (32'(top_count) > MaxTop)       k_eff = FW'(MaxTop);
      else                                    k_eff = FW'(top_count);
   end

   // The sum is at least 1.0, so the quotient fits in 17 bits: the top 15
   // dividend bits go straight into the remainder and 18 steps do the rest.
   assign num_load = {e_val, 16'd0} + 33'(sum_ff >> 1);
   assign rem_sh   = {rem_ff[SumW-1:0], num_ff[32]};
   assign trial    = rem_sh - {1'b0, sum_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (pop && q_head.last) state_in = ST_SUM_RD;
         ST_SUM_RD:    if (rd_ff == cnt_ff && pv_ff == '0) state_in = ST_DIV_SETUP;
         ST_DIV_SETUP: state_in = (n_ff == '0) ? ST_IDLE : ST_DIV_RUN;
         ST_DIV_RUN:   if (bit_ff == 5'd0) state_in = ST_EMIT;
         ST_EMIT:      state_in = (FW'(r_ff) + 1'b1 == n_ff) ? ST_IDLE : ST_DIV_SETUP;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Pipeline: read address in rd_ff, then the registered RAM data, then the
   // exp registers; pv_ff follows them and gates the accumulation into sum_ff.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rd_ff    <= '0;
         pv_ff    <= '0;
         sum_ff   <= '0;
         r_ff     <= '0;
         n_ff     <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (ins) cnt_ff <= cnt_ff + 1'b1;
         case (state_ff)
            ST_IDLE: begin
               rd_ff  <= '0;
               pv_ff  <= '0;
               sum_ff <= '0;
               r_ff   <= '0;
               n_ff   <= '0;
            end
            ST_SUM_RD: begin
               pv_ff <= {pv_ff[0], (rd_ff != cnt_ff)};
               if (rd_ff != cnt_ff) begin
                  rd_ff <= rd_ff + 1'b1;
               end else if (pv_ff == '0) begin
                  n_ff   <= (k_eff < filled) ? k_eff : filled;
                  cnt_ff <= '0;
               end
               if (pv_ff[1]) sum_ff <= sum_ff + SumW'(te_val);
            end
            ST_DIV_SETUP: begin
               bit_ff <= 5'd20;
            end
            ST_DIV_RUN: begin
               bit_ff <= bit_ff - 1'b1;
            end
            ST_EMIT: begin
               r_ff <= r_ff + 1'b1;
            end
            default: ;
         endcase
      end
      // Exp pipeline registers (payload).
      t_ff  <= t_prod[32:16];
      lo_ff <= {(d[16:12] != '0), 1'b0, d[3:0]};
      // Restoring division of e*65536 + sum/2 by sum, one quotient bit a cycle.
      if (state_ff == ST_DIV_RUN && bit_ff > 5'd17) begin
         // wait for the exp value of this entry to settle
         if (bit_ff == 5'd18) begin
            rem_ff <= (SumW+1)'(num_load[32:18]);
            num_ff <= {num_load[17:0], 15'd0};
            quo_ff <= '0;
         end
      end else if (state_ff == ST_DIV_RUN) begin
         num_ff <= {num_ff[31:0], 1'b0};
         if (rem_sh >= {1'b0, sum_ff}) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
      end
   end

   assign cnt_sat   = quo_ff;
   assign out_valid = (state_ff == ST_EMIT);
   assign out_index = best_ix;
   assign out_prob  = (cnt_sat > 17'd65535) ? 16'hFFFF : cnt_sat[15:0];
   assign out_final = (FW'(r_ff) + 1'b1 == n_ff);
   assign working   = (state_ff != ST_IDLE) || q_valid;
endmodule

>>> sv/softmax_top_k_select_top.sv
// Top level of the streaming softmax with top-k selection.
// Depends on smx_topk_pkg, smx_topk_front, smx_topk_back and the macros header.
//
// Scores arrive one per cycle as requests (start while busy is low) and are
// queued by the front part; the back part stores each score in a RAM and
// inserts it into a sorted row of cells, so the sustained rate is one
// request per cycle while a vector streams in. After the request marked
// last, the back part reads every stored score back through the RAM port,
// one per cycle, then produces each reported class with a one-bit-per-cycle
// divider. Results appear for one cycle under rsp_valid and cannot be held
// off; busy stays high when the queue is full and requests then wait.
`include "softmax_top_k_select_top_macros.svh"
module softmax_top_k_select_top
   import smx_topk_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault,
   parameter int MaxTop     = MaxTopDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [ScoreWidth-1:0] req_logit,
   input  logic                         req_last,
   input  logic                         csr_wr_en,
   input  logic [TopWidth-1:0]          csr_wr_data,
   output logic                         rsp_valid,
   output logic [IndexWidth-1:0]        rsp_class_index,
   output logic [ProbWidth-1:0]         rsp_probability,
   output logic                         rsp_final_result
);
   logic [TopWidth-1:0] top_count_ff;
   logic                full, pop, q_valid, working;
   smx_req_type         q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TopWidth'(TopCountReset);
      end else if (csr_wr_en) begin
         top_count_ff <= csr_wr_data;
      end
   end

   assign busy = full;

   smx_topk_front #(.MaxClasses(MaxClasses)) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .logit   (req_logit),
      .last    (req_last),
      .full    (full),
      .pop     (pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   smx_topk_back #(.MaxClasses(MaxClasses), .MaxTop(MaxTop)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .top_count (top_count_ff),
      .out_valid (rsp_valid),
      .out_index (rsp_class_index),
      .out_prob  (rsp_probability),
      .out_final (rsp_final_result),
      .working   (working)
   );

   // A pop can only happen when the queue holds something.
   `SMX_ASSERT_IMPL(a_pop_valid, clock, reset, pop, q_valid, "pop from empty queue")
   // A result is never shown while the back part is idle.
   `SMX_ASSERT_IMPL(a_rsp_work, clock, reset, rsp_valid, working, "result while idle")
   // A final result ends the vector: no result follows in the next cycle.
   `SMX_ASSERT_NEXT(a_final_gap, clock, reset, rsp_valid && rsp_final_result, !rsp_valid,
      "result right after final")
endmodule

>>> sim/smx_topk_checker.sv
// Checker for the top-k softmax block: watches the request, result and CSR ports.
// Predicts every result of the block and compares it field by field.
// Depends on smx_topk_pkg for widths and sizes.
module smx_topk_checker
   import smx_topk_pkg::*;
#(
   parameter int MaxClasses = MaxClassesDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic signed [ScoreWidth-1:0] req_logit,
   input  logic                         req_last,
   input  logic                         csr_wr_en,
   input  logic [TopWidth-1:0]          csr_wr_data,
   input  logic                         rsp_valid,
   input  logic [IndexWidth-1:0]        rsp_class_index,
   input  logic [ProbWidth-1:0]         rsp_probability,
   input  logic                         rsp_final_result,
   output int                           fail_count,
   output int                           pending
);
   typedef struct {
      logic [IndexWidth-1:0] class_index;
      logic [ProbWidth-1:0]  probability;
      logic                  final_result;
   } class_result_type;

   class_result_type expected_q[$];

   int unsigned whole_tab[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
   int unsigned sixteenth_tab[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                      39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
   int unsigned fine_tab[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                                 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

   logic signed [ScoreWidth-1:0] vector_scores[MaxClasses];
   int                           vector_len;
   int                           leader_index[MaxTopDefault];
   logic signed [ScoreWidth-1:0] leader_score[MaxTopDefault];
   int                           leaders;
   logic [TopWidth-1:0]          top_count;

   // exp(-d) for an unsigned Q8.8 distance below the maximum, in Q1.16.
   function automatic longint unsigned exp_of_distance(int unsigned d);
      longint unsigned t;
      if ((d >> 8) >= 12) return 0;
      t = (longint'(whole_tab[d >> 8]) * sixteenth_tab[(d >> 4) & 15] + 32768) >> 16;
      return (t * fine_tab[d & 15] + 32768) >> 16;
   endfunction

   // Sorted insertion; on equal scores the earlier class stays ahead.
   task automatic rank_score(int idx, logic signed [ScoreWidth-1:0] s);
      int pos;
      int j;
      pos = leaders;
      while (pos > 0 && leader_score[pos-1] < s) pos--;
      if (pos < MaxTopDefault) begin
         j = (leaders < MaxTopDefault) ? leaders : MaxTopDefault - 1;
         while (j > pos) begin
            leader_index[j] = leader_index[j-1];
            leader_score[j] = leader_score[j-1];
            j--;
         end
         leader_index[pos] = idx;
         leader_score[pos] = s;
         if (leaders < MaxTopDefault) leaders++;
      end
   endtask

   task automatic absorb_request(logic signed [ScoreWidth-1:0] s, logic is_last);
      int                           k;
      int                           n;
      int                           peak;
      longint unsigned              total;
      longint unsigned              e;
      longint unsigned              p;
      class_result_type             r;
      if (vector_len < MaxClasses) begin
         vector_scores[vector_len] = s;
         rank_score(vector_len, s);
         vector_len++;
      end
      if (is_last) begin
         peak = (leaders > 0) ? int'(leader_score[0]) : 0;
         total = 0;
         for (int i = 0; i < vector_len; i++)
            total += exp_of_distance(peak - int'(vector_scores[i]));
         k = (top_count == 0) ? 1 : ((top_count > MaxTopDefault) ? MaxTopDefault : top_count);
         n = (k < leaders) ? k : leaders;
         for (int i = 0; i < n; i++) begin
            e = exp_of_distance(peak - int'(leader_score[i]));
            p = (total != 0) ? (e * 65536 + total / 2) / total : 0;
            if (p > 65535) p = 65535;
            r.class_index  = IndexWidth'(leader_index[i]);
            r.probability  = p[ProbWidth-1:0];
            r.final_result = (i + 1 == n);
            expected_q = {expected_q, r};
         end
         vector_len = 0;
         leaders = 0;
      end
   endtask

   task automatic report(string field, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      class_result_type w;
      if (reset) begin
         expected_q.delete();
         vector_len = 0;
         leaders = 0;
         fail_count = 0;
         top_count = TopWidth'(TopCountReset);
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report("unexpected result, class", rsp_class_index, -1);
            end else begin
               w = expected_q.pop_front();
               if (rsp_class_index !== w.class_index)
                  report("class_index", rsp_class_index, w.class_index);
               if (rsp_probability !== w.probability)
                  report("probability", rsp_probability, w.probability);
               if (rsp_final_result !== w.final_result)
                  report("final_result", rsp_final_result, w.final_result);
            end
         end
         if (csr_wr_en) top_count = csr_wr_data;
         if (start && !busy) absorb_request(req_logit, req_last);
      end
      pending = expected_q.size();
   end
endmodule

>>> sim/tb.sv
// Testbench top for softmax_top_k_select_top: clock, reset, stimulus and verdict.
// Depends on smx_topk_pkg, the block itself and smx_topk_checker.
module tb;
   import smx_topk_pkg::*;

   // Score store depth used for this run; small, so that the overflow case
   // fits in a short run.
   localparam int StoreDepth = 64;
   // No request or result for this many cycles means the block has hung. The
   // longest legal quiet stretch is the sum pass over a full vector plus a
   // divider run, a long sender gap and the settle time.
   localparam int IdleLimit = 2000;
   // Quiet cycles allowed after the last result before the CSR is touched or
   // the run ends, so any trailing work in the back part has settled.
   localparam int SettleCycles = 60;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [ScoreWidth-1:0] req_logit = '0;
   logic                         req_last = 1'b0;
   logic                         csr_wr_en = 1'b0;
   logic [TopWidth-1:0]          csr_wr_data = '0;
   logic                         rsp_valid;
   logic [IndexWidth-1:0]        rsp_class_index;
   logic [ProbWidth-1:0]         rsp_probability;
   logic                         rsp_final_result;
   int                           fail_count;
   int                           pending;
   int                           quiet_cycles = 0;
   bit                           bursty = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   softmax_top_k_select_top #(.MaxClasses(StoreDepth)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_logit       (req_logit),
      .req_last        (req_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_class_index (rsp_class_index),
      .rsp_probability (rsp_probability),
      .rsp_final_result(rsp_final_result)
   );

   smx_topk_checker #(.MaxClasses(StoreDepth)) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_logit       (req_logit),
      .req_last        (req_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_class_index (rsp_class_index),
      .rsp_probability (rsp_probability),
      .rsp_final_result(rsp_final_result),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // Watchdog: any accepted request or any result restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("[softmax_top_k_select_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly back-to-back or short gaps, now and then a long one. While the
   // bursty flag is clear the sender never pauses.
   function automatic int pick_gap();
      int r;
      if (!bursty) return 0;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Presents one request and holds it until the block takes it. Busy only
   // moves on a rising edge, so the value seen at the falling edge decides
   // whether the next rising edge accepts the request.
   task automatic send_score(logic signed [ScoreWidth-1:0] s, logic is_last);
      bit taken;
      int gap;
      start     <= 1'b1;
      req_logit <= s;
      req_last  <= is_last;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers start and waits until every predicted result has come out.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // The block must be idle here; drain() is always called first.
   task automatic write_top_count(logic [TopWidth-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // A mix of score shapes: full-range noise, values clustered near a base so
   // the probabilities are interesting, ties from a small set, and the rails.
   function automatic logic signed [ScoreWidth-1:0] pick_score(int base);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return ScoreWidth'($urandom_range(0, 65535));
      if (r < 7) return ScoreWidth'(base + int'($urandom_range(0, 1023)) - 512);
      if (r < 9) return ScoreWidth'(256 * int'($urandom_range(0, 3)) - 256);
      return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
   endfunction

   task automatic send_vector(int len);
      int base;
      base = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < len; i++)
         send_score(pick_score(base), i == len - 1);
   endtask

   initial begin
      int sent;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the reset top count of five.
      // A lone score: probability 1.0 saturates.
      send_score(16'sh7fff, 1'b1);
      // The widest possible distance gives an exp of zero.
      send_score(16'sh8000, 1'b0);
      send_score(16'sh7fff, 1'b1);
      // Ties must keep the lower class index first.
      send_score(16'sh0100, 1'b0);
      send_score(16'sh0100, 1'b0);
      send_score(16'sh0100, 1'b0);
      send_score(16'sh0000, 1'b1);
      // Distances that walk every table: whole, sixteenth and fine steps.
      send_score(16'sh0000, 1'b0);
      send_score(-16'sh0001, 1'b0);
      send_score(-16'sh0010, 1'b0);
      send_score(-16'sh0100, 1'b0);
      send_score(-16'sh0bff, 1'b0);
      send_score(-16'sh0c00, 1'b0);
      send_score(-16'sh0fff, 1'b1);
      drain();

      // Top count of zero is treated as one.
      write_top_count(4'd0);
      for (int i = 0; i < 4; i++) send_score(16'sh0200 - 16'(i * 16), i == 3);
      drain();

      // Top count above the row size is treated as eight, with more than
      // eight classes so the row overflows.
      write_top_count(4'd15);
      for (int i = 0; i < 10; i++) send_score(16'(i * 37) - 16'sh0080, i == 9);
      drain();

      // A vector longer than the score store: the tail is dropped but the
      // marked last score still ends the vector.
      write_top_count(4'd8);
      bursty = 1'b0;
      send_vector(StoreDepth + 6);
      bursty = 1'b1;
      drain();

      // Random part: short vectors with random content, the top count moved
      // between phases across its whole range.
      write_top_count(4'd1);
      sent = 0;
      while (sent < 250) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 12);
         send_vector(len);
         sent += len;
         if ($urandom_range(0, 7) == 0) begin
            drain();
            write_top_count(TopWidth'($urandom_range(0, 15)));
            bursty = $urandom_range(0, 2) != 0;
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("[softmax_top_k_select_top] OK");
      end else begin
         $display("[softmax_top_k_select_top] ERROR");
      end
      $finish;
   end
endmodule
